FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared clocked assertion forms. They expect clk and rst in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, off during reset
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked through reset as well
`define ASSERT_NEXT_ALWAYS(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: src/msip_pkg.sv
// ----------------------------------------------------------------------------
// msip_pkg
// Types, widths and register codes shared by the motor speed PID block.
// ----------------------------------------------------------------------------
package msip_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_PROP      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_INTEG     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_DERIV     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_FLOOR    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_CEILING  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SPIN_THRESHOLD = 3'd5;

  // Register reset values
  localparam logic [23:0]        GAIN_PROP_RST      = 24'd92160;
  localparam logic [23:0]        GAIN_INTEG_RST     = 24'd1664;
  localparam logic [23:0]        GAIN_DERIV_RST     = 24'd0;
  localparam logic signed [15:0] DRIVE_FLOOR_RST    = -16'sd9999;
  localparam logic signed [15:0] DRIVE_CEILING_RST  = 16'sd9999;
  localparam logic [14:0]        SPIN_THRESHOLD_RST = 15'd180;

  // Error path widths
  localparam int ERR_W  = 18;   // filter minus setpoint
  localparam int D1_W   = 19;   // first difference
  localparam int D2_W   = 20;   // second difference
  localparam int GAIN_W = 24;

  // Product and accumulation widths
  localparam int PPROP_W  = GAIN_W + 1 + D1_W;
  localparam int PINTEG_W = GAIN_W + 1 + ERR_W;
  localparam int PDERIV_W = GAIN_W + 1 + D2_W;
  localparam int INCR_W   = 46;
  localparam int SUM_W    = 47;

  // Reciprocal of ten for a 15-bit dividend
  localparam logic [15:0] RECIP_TEN       = 16'd52429;
  localparam int          RECIP_TEN_SHIFT = 19;

  typedef struct packed {
    logic signed [D1_W-1:0]  d1;
    logic signed [D2_W-1:0]  d2;
    logic signed [ERR_W-1:0] err;
    logic signed [15:0]      filt;
    logic signed [15:0]      setp;
    logic                    wdog;
  } front_out_t;

  typedef struct packed {
    logic [GAIN_W-1:0]  gain_prop;
    logic [GAIN_W-1:0]  gain_integ;
    logic [GAIN_W-1:0]  gain_deriv;
    logic signed [15:0] drive_floor;
    logic signed [15:0] drive_ceiling;
  } pid_cfg_t;

  typedef struct packed {
    logic mul_load;
    logic acc_load;
  } pid_ctrl_t;

endpackage

FILE: src/msip_front.sv
// ----------------------------------------------------------------------------
// msip_front
// Setpoint ramp, speed filter and error history; one item per cycle while load is high.
// ----------------------------------------------------------------------------
module msip_front #(
  parameter int START_TICK_PERIOD = 3
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  logic [15:0]          encoder_raw,
  input  logic signed [15:0]   target_speed,
  input  logic                 stop_request,
  input  logic [14:0]          spin_threshold,
  output msip_pkg::front_out_t q
);
  import msip_pkg::*;

  localparam int TICK_W = $clog2(START_TICK_PERIOD + 1);

  logic signed [15:0]      setpoint;
  logic                    start_done;
  logic [TICK_W-1:0]       start_ticks;
  logic signed [15:0]      speed_filter;
  logic signed [ERR_W-1:0] error_last;
  logic signed [ERR_W-1:0] error_before_last;

  logic signed [15:0]      setpoint_next;
  logic                    start_done_next;
  logic [TICK_W-1:0]       start_ticks_next;
  logic signed [15:0]      speed_filter_next;
  logic signed [ERR_W-1:0] err;

  logic [TICK_W-1:0]       ticks_inc;
  logic [30:0]             tenth_prod;
  logic signed [16:0]      ramp_sum;
  logic signed [18:0]      filt_sum;
  logic signed [18:0]      filt_biased;
  logic [15:0]             filt_abs;

  // Tenth of the target; only used while the target is positive
  assign tenth_prod = 31'(target_speed[14:0]) * 31'(RECIP_TEN);
  assign ramp_sum   = 17'(setpoint) + 17'($signed({1'b0, tenth_prod[30:RECIP_TEN_SHIFT]}));
  assign ticks_inc  = start_ticks + 1'b1;

  // Ramp the setpoint up toward the target, or down to zero on a stop request
  always_comb begin
    setpoint_next    = setpoint;
    start_done_next  = start_done;
    start_ticks_next = start_ticks;
    if (!stop_request) begin
      if ((setpoint < target_speed) && !start_done) begin
        if (ticks_inc >= TICK_W'(START_TICK_PERIOD)) begin
          setpoint_next    = (ramp_sum > 17'sd32767) ? 16'sd32767 : ramp_sum[15:0];
          start_ticks_next = '0;
        end else begin
          start_ticks_next = ticks_inc;
        end
      end else begin
        setpoint_next   = target_speed;
        start_done_next = 1'b1;
      end
    end else begin
      setpoint_next = (setpoint <= 16'sd0) ? 16'sd0 : setpoint - 16'sd1;
    end
  end

  // Filter: trunc((3*f - speed) / 4)
  assign filt_sum    = (19'(speed_filter) <<< 1) + 19'(speed_filter)
                       - 19'($signed(encoder_raw));
  assign filt_biased = filt_sum + (filt_sum[18] ? 19'sd3 : 19'sd0);
  assign speed_filter_next = 16'(filt_biased >>> 2);
  assign filt_abs    = speed_filter_next[15] ? 16'(-speed_filter_next)
                                             : 16'(speed_filter_next);

  assign err = ERR_W'(speed_filter_next) - ERR_W'(setpoint_next);

  // Advance state on each transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint          <= '0;
      start_done        <= 1'b0;
      start_ticks       <= '0;
      speed_filter      <= '0;
      error_last        <= '0;
      error_before_last <= '0;
    end else if (load) begin
      setpoint          <= setpoint_next;
      start_done        <= start_done_next;
      start_ticks       <= start_ticks_next;
      speed_filter      <= speed_filter_next;
      error_last        <= err;
      error_before_last <= error_last;
    end
  end

  // Stage register for the PID
  always_ff @(posedge clk) begin
    if (load) begin
      q.d1   <= D1_W'(err) - D1_W'(error_last);
      q.d2   <= D2_W'(err) - (D2_W'(error_last) <<< 1) + D2_W'(error_before_last);
      q.err  <= err;
      q.filt <= speed_filter_next;
      q.setp <= setpoint_next;
      q.wdog <= filt_abs < {1'b0, spin_threshold};
    end
  end

endmodule

FILE: src/msip_pid.sv
// ----------------------------------------------------------------------------
// msip_pid
// Gain multiplies, then accumulate, clamp and form the motor drive.
// ----------------------------------------------------------------------------
module msip_pid #(
  parameter int GAIN_FRAC_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  msip_pkg::pid_ctrl_t  ctrl,
  input  msip_pkg::pid_cfg_t   cfg,
  input  msip_pkg::front_out_t front,
  output logic signed [15:0]   motor_drive,
  output logic signed [15:0]   filtered_speed,
  output logic signed [15:0]   setpoint_now,
  output logic                 watchdog_ok
);
  import msip_pkg::*;

  localparam int ACC_W = 16 + GAIN_FRAC_BITS;
  localparam logic [SUM_W-1:0] FRAC_MASK = (SUM_W'(1) << GAIN_FRAC_BITS) - SUM_W'(1);

  logic signed [GAIN_W:0]     kp_s;
  logic signed [GAIN_W:0]     ki_s;
  logic signed [GAIN_W:0]     kd_s;
  logic signed [PPROP_W-1:0]  p_prop;
  logic signed [PINTEG_W-1:0] p_integ;
  logic signed [PDERIV_W-1:0] p_deriv;
  logic signed [15:0]         filt2;
  logic signed [15:0]         setp2;
  logic                       wdog2;

  logic signed [ACC_W-1:0]    drive_accum;
  logic signed [INCR_W-1:0]   incr;
  logic signed [SUM_W-1:0]    acc_sum;
  logic signed [SUM_W-1:0]    floor_s;
  logic signed [SUM_W-1:0]    ceil_s;
  logic signed [SUM_W-1:0]    acc_lo;
  logic signed [SUM_W-1:0]    acc_clamp;
  logic signed [SUM_W-1:0]    int_full;
  logic signed [15:0]         int_part;
  logic signed [16:0]         neg_int;

  assign kp_s = $signed({1'b0, cfg.gain_prop});
  assign ki_s = $signed({1'b0, cfg.gain_integ});
  assign kd_s = $signed({1'b0, cfg.gain_deriv});

  // Multiply stage
  always_ff @(posedge clk) begin
    if (ctrl.mul_load) begin
      p_prop  <= kp_s * front.d1;
      p_integ <= ki_s * front.err;
      p_deriv <= kd_s * front.d2;
      filt2   <= front.filt;
      setp2   <= front.setp;
      wdog2   <= front.wdog;
    end
  end

  // Accumulate and clamp; the ceiling wins over the floor
  assign incr      = INCR_W'(p_prop) + INCR_W'(p_integ) + INCR_W'(p_deriv);
  assign acc_sum   = SUM_W'(incr) + SUM_W'(drive_accum);
  assign floor_s   = SUM_W'(cfg.drive_floor) <<< GAIN_FRAC_BITS;
  assign ceil_s    = SUM_W'(cfg.drive_ceiling) <<< GAIN_FRAC_BITS;
  assign acc_lo    = (acc_sum < floor_s) ? floor_s : acc_sum;
  assign acc_clamp = (acc_lo > ceil_s) ? ceil_s : acc_lo;

  // Integer part truncated toward zero, then negate with saturation
  assign int_full = (acc_clamp + (acc_clamp[SUM_W-1] ? $signed(FRAC_MASK) : '0))
                    >>> GAIN_FRAC_BITS;
  assign int_part = int_full[15:0];
  assign neg_int  = -$signed({int_part[15], int_part});

  always_ff @(posedge clk) begin
    if (rst) begin
      drive_accum <= '0;
    end else if (ctrl.acc_load) begin
      drive_accum <= acc_clamp[ACC_W-1:0];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (ctrl.acc_load) begin
      motor_drive    <= (neg_int == 17'sd32768) ? 16'sd32767 : neg_int[15:0];
      filtered_speed <= filt2;
      setpoint_now   <= setp2;
      watchdog_ok    <= wdog2;
    end
  end

endmodule

FILE: src/motor_speed_incremental_pid.sv
// ----------------------------------------------------------------------------
// motor_speed_incremental_pid
// Stages from input transfer to result valid: ramp/filter stage, gain multiply
// stage, accumulate/clamp stage. Throughput: one item per cycle while out_stall
// is low; each stage holds one item and moves on when the next one is free.
// Reset (rst, synchronous): clears loop state and pipeline valids and loads
// the register defaults.
// ----------------------------------------------------------------------------
module motor_speed_incremental_pid #(
  parameter int GAIN_FRAC_BITS    = 8,
  parameter int START_TICK_PERIOD = 3
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [msip_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [msip_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [15:0]                       encoder_raw,
  input  logic signed [15:0]                target_speed,
  input  logic                              stop_request,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [15:0]                motor_drive,
  output logic signed [15:0]                filtered_speed,
  output logic signed [15:0]                setpoint_now,
  output logic                              watchdog_ok
);
  import msip_pkg::*;

  pid_cfg_t    cfg;
  logic [14:0] spin_threshold;
  pid_ctrl_t   ctrl;
  front_out_t  front;

  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3;
  logic accept;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_prop     <= GAIN_PROP_RST;
      cfg.gain_integ    <= GAIN_INTEG_RST;
      cfg.gain_deriv    <= GAIN_DERIV_RST;
      cfg.drive_floor   <= DRIVE_FLOOR_RST;
      cfg.drive_ceiling <= DRIVE_CEILING_RST;
      spin_threshold    <= SPIN_THRESHOLD_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_GAIN_PROP:      cfg.gain_prop     <= cfg_data;
        REG_GAIN_INTEG:     cfg.gain_integ    <= cfg_data;
        REG_GAIN_DERIV:     cfg.gain_deriv    <= cfg_data;
        REG_DRIVE_FLOOR:    cfg.drive_floor   <= cfg_data[15:0];
        REG_DRIVE_CEILING:  cfg.drive_ceiling <= cfg_data[15:0];
        REG_SPIN_THRESHOLD: spin_threshold    <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // Stage flow control: a stage loads when it is empty or moving on
  assign rdy3     = !v3 || !out_stall;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_stall = !rdy1;
  assign accept   = in_valid && rdy1;
  assign out_valid = v3;

  assign ctrl.mul_load = rdy2 && v1;
  assign ctrl.acc_load = rdy3 && v2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  msip_front #(
    .START_TICK_PERIOD(START_TICK_PERIOD)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .load           (accept),
    .encoder_raw    (encoder_raw),
    .target_speed   (target_speed),
    .stop_request   (stop_request),
    .spin_threshold (spin_threshold),
    .q              (front)
  );

  msip_pid #(
    .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
  ) u_pid (
    .clk            (clk),
    .rst            (rst),
    .ctrl           (ctrl),
    .cfg            (cfg),
    .front          (front),
    .motor_drive    (motor_drive),
    .filtered_speed (filtered_speed),
    .setpoint_now   (setpoint_now),
    .watchdog_ok    (watchdog_ok)
  );

endmodule

FILE: src/msip_checker.sv
// ----------------------------------------------------------------------------
// msip_checker
// Port-level checks on the motor speed PID block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module msip_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [15:0] motor_drive,
  input logic signed [15:0] filtered_speed,
  input logic signed [15:0] setpoint_now,
  input logic               watchdog_ok
);

  // Gather the result fields for the hold check
  logic [48:0] result_bits;
  assign result_bits = {motor_drive, filtered_speed, setpoint_now, watchdog_ok};

  // No result right after reset
  `ASSERT_NEXT_ALWAYS(a_reset_empty, rst, !out_valid)

  // A stalled result holds
  `ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(result_bits))

  // Input stalls only when the output is backed up
  `ASSERT_SAME(a_stall_backpressure, in_stall, out_valid && out_stall)

  // Negated drive saturates instead of wrapping
  `ASSERT_SAME(a_drive_saturated, out_valid, motor_drive != 16'sh8000)

endmodule

bind motor_speed_incremental_pid msip_checker u_msip_checker (.*);
